// File: rtl/core/dhks_pkg.sv
// Package for the double-hashed key set: sizes, codes and the records that
// travel between the front queue, the probe engine and the result queue.
// Depends on nothing.
`timescale 1ns / 1ps

package dhks_pkg;

    localparam int TABLE_SIZE = 4096;
    localparam int ADDR_W     = $clog2(TABLE_SIZE);
    localparam int COUNT_W    = $clog2(TABLE_SIZE + 1);
    localparam int KEY_W      = 160;
    localparam int FLAG_W     = 8;
    localparam int SLOT_W     = 12;
    localparam int HOME_W     = 19;
    localparam int STRIDE_W   = 16;

    localparam logic [ADDR_W-1:0] LAST_SLOT      = ADDR_W'(TABLE_SIZE - 1);
    localparam logic [FLAG_W-1:0] FLAG_PROCESSED = FLAG_W'(1);

    typedef enum logic {
        FUNC_LOOKUP = 1'b0,
        FUNC_INSERT = 1'b1
    } t_func;

    typedef struct packed {
        t_func              func;
        logic [KEY_W-1:0]   key;
        logic [FLAG_W-1:0]  flag;
        logic [ADDR_W-1:0]  home;
        logic [ADDR_W-1:0]  stride;
    } t_cmd;

    typedef struct packed {
        logic               found;
        logic [FLAG_W-1:0]  flag_out;
        logic               processed;
        logic [SLOT_W-1:0]  slot;
        logic               newly_added;
        logic               table_full;
        logic [COUNT_W-1:0] entry_count;
    } t_res;

    typedef struct packed {
        logic take;
        logic ready;
    } t_eng_ctl;

endpackage

// File: rtl/core/double_hash_key_set_top.sv
// Top level of the double-hashed key set: front queue, probe engine and
// result queue. Depends on dhks_pkg, dhks_front, dhks_engine and dhks_outq.
//
// After reset the block sweeps the 4096-entry key memory to zero, one slot a
// cycle, and holds full high until the sweep is done. Afterwards an operation
// is taken into the probe engine, walks its probes (one key memory read and
// compare each, few on a lightly loaded table and at most 4096 when the table
// is full) and then hands its result on. A two-entry command queue
// in front and a two-entry result queue behind let transfers on either side
// continue while the engine works or the consumer stalls.
`timescale 1ns / 1ps

module double_hash_key_set_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          i_func,
    input  logic [63:0]                   i_key_upper,
    input  logic [63:0]                   i_key_middle,
    input  logic [31:0]                   i_key_lower,
    input  logic [7:0]                    i_flag_in,
    output logic                          empty,
    input  logic                          pop,
    output logic                          o_found,
    output logic [7:0]                    o_flag_out,
    output logic                          o_processed,
    output logic [dhks_pkg::SLOT_W-1:0]   o_slot,
    output logic                          o_newly_added,
    output logic                          o_table_full,
    output logic [dhks_pkg::COUNT_W-1:0]  o_entry_count
);
    import dhks_pkg::*;

    t_eng_ctl eng_ctl;
    logic     cmd_valid;
    t_cmd     cmd;
    logic     res_push;
    logic     res_full;
    t_res     eng_res;
    t_res     out_res;

    dhks_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_func       (i_func),
        .i_key_upper  (i_key_upper),
        .i_key_middle (i_key_middle),
        .i_key_lower  (i_key_lower),
        .i_flag_in    (i_flag_in),
        .i_eng        (eng_ctl),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd)
    );

    dhks_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_ctl       (eng_ctl),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (eng_res)
    );

    dhks_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (eng_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_res   (out_res)
    );

    assign o_found       = out_res.found;
    assign o_flag_out    = out_res.flag_out;
    assign o_processed   = out_res.processed;
    assign o_slot        = out_res.slot;
    assign o_newly_added = out_res.newly_added;
    assign o_table_full  = out_res.table_full;
    assign o_entry_count = out_res.entry_count;

endmodule

// File: rtl/core/dhks_front.sv
// Front end: takes input transfers, forms the key and its home slot and
// stride, and holds up to two commands for the probe engine.
// Depends on dhks_pkg.
`timescale 1ns / 1ps

module dhks_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    output logic                       o_full,
    input  logic                       i_func,
    input  logic [63:0]                i_key_upper,
    input  logic [63:0]                i_key_middle,
    input  logic [31:0]                i_key_lower,
    input  logic [dhks_pkg::FLAG_W-1:0] i_flag_in,
    input  dhks_pkg::t_eng_ctl         i_eng,
    output logic                       o_cmd_valid,
    output dhks_pkg::t_cmd             o_cmd
);
    import dhks_pkg::*;

    t_cmd                r_q [2];
    logic                r_wr_ptr, n_wr_ptr;
    logic                r_rd_ptr, n_rd_ptr;
    logic [1:0]          r_cnt, n_cnt;
    logic                push_ok;
    logic                pop_ok;
    t_cmd                new_cmd;
    logic [HOME_W-1:0]   home_raw;
    logic [STRIDE_W-1:0] stride_raw;

    assign new_cmd.key  = {i_key_upper, i_key_middle, i_key_lower};
    assign new_cmd.func = t_func'(i_func);
    assign new_cmd.flag = i_flag_in;
    assign home_raw     = i_key_upper[63:45];
    assign stride_raw   = {i_key_upper[31:24], i_key_upper[39:32]} | STRIDE_W'(1);
    assign new_cmd.home   = ADDR_W'(home_raw);
    assign new_cmd.stride = ADDR_W'(stride_raw);

    assign o_full      = (r_cnt == 2'd2) || !i_eng.ready;
    assign push_ok     = i_push && !o_full;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop_ok      = i_eng.take && o_cmd_valid;
    assign o_cmd       = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ push_ok;
        n_rd_ptr = r_rd_ptr ^ pop_ok;
        n_cnt    = r_cnt + 2'(push_ok) - 2'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wr_ptr] <= new_cmd;
        end
    end

endmodule

// File: rtl/core/dhks_engine.sv
// Probe engine: clears the key memory after reset, walks the probe sequence
// one memory read per cycle, writes inserts and keeps the entry count.
// Depends on dhks_pkg.
`timescale 1ns / 1ps

module dhks_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  dhks_pkg::t_cmd     i_cmd,
    output dhks_pkg::t_eng_ctl o_ctl,
    input  logic               i_res_full,
    output logic               o_res_push,
    output dhks_pkg::t_res     o_res
);
    import dhks_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_PROBE = 4'b0100,
        S_STORE = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    logic [ADDR_W-1:0]    r_clr_addr, n_clr_addr;
    logic [COUNT_W-1:0]   r_count, n_count;
    t_cmd                 r_cmd, n_cmd;
    logic [ADDR_W-1:0]    r_pos, n_pos;
    logic [ADDR_W-1:0]    r_probes, n_probes;
    logic                 r_hit_empty, n_hit_empty;
    logic                 r_miss, n_miss;

    logic [KEY_W-1:0]     r_key_mem [TABLE_SIZE];
    logic [FLAG_W-1:0]    r_flag_mem [TABLE_SIZE];
    logic [KEY_W-1:0]     r_rd_key;
    logic [FLAG_W-1:0]    r_rd_flag;

    logic                 key_we;
    logic                 flag_we;
    logic [ADDR_W-1:0]    waddr;
    logic [KEY_W-1:0]     wkey;
    logic                 mem_re;
    logic [ADDR_W-1:0]    raddr;
    logic                 rd_empty;
    logic                 hit;
    logic                 do_write;
    logic                 found;

    assign rd_empty = (r_rd_key == '0);
    assign hit      = rd_empty || (r_rd_key == r_cmd.key);
    assign do_write = (r_cmd.func == FUNC_INSERT) && !r_miss;
    assign found    = !r_miss && !r_hit_empty;

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_count     = r_count;
        n_cmd       = r_cmd;
        n_pos       = r_pos;
        n_probes    = r_probes;
        n_hit_empty = r_hit_empty;
        n_miss      = r_miss;
        key_we      = 1'b0;
        flag_we     = 1'b0;
        waddr       = r_pos;
        wkey        = r_cmd.key;
        mem_re      = 1'b0;
        raddr       = r_pos;
        o_ctl.take  = 1'b0;
        o_ctl.ready = (r_state != S_CLEAR);
        o_res_push  = 1'b0;
        case (r_state)
            S_CLEAR: begin
                key_we     = 1'b1;
                waddr      = r_clr_addr;
                wkey       = '0;
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == LAST_SLOT) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_ctl.take = 1'b1;
                    n_cmd      = i_cmd;
                    n_pos      = i_cmd.home;
                    n_probes   = '0;
                    mem_re     = 1'b1;
                    raddr      = i_cmd.home;
                    n_state    = S_PROBE;
                end
            end
            S_PROBE: begin
                if (hit || (r_probes == LAST_SLOT)) begin
                    n_hit_empty = rd_empty;
                    n_miss      = !hit;
                    n_state     = S_STORE;
                end else begin
                    n_pos    = r_pos + r_cmd.stride;
                    n_probes = r_probes + ADDR_W'(1);
                    mem_re   = 1'b1;
                    raddr    = n_pos;
                end
            end
            S_STORE: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    key_we     = do_write;
                    flag_we    = do_write;
                    if (do_write && r_hit_empty && (r_cmd.key != '0)) begin
                        n_count = r_count + COUNT_W'(1);
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_res.found       = found;
    assign o_res.flag_out    = found ? r_rd_flag : '0;
    assign o_res.processed   = found && (r_rd_flag == FLAG_PROCESSED);
    assign o_res.slot        = SLOT_W'(r_pos);
    assign o_res.newly_added = do_write && r_hit_empty && (r_cmd.key != '0);
    assign o_res.table_full  = r_miss;
    assign o_res.entry_count = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_count    <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_count    <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_pos       <= n_pos;
        r_probes    <= n_probes;
        r_hit_empty <= n_hit_empty;
        r_miss      <= n_miss;
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_key_mem[waddr] <= wkey;
        end
        if (mem_re) begin
            r_rd_key <= r_key_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (flag_we) begin
            r_flag_mem[waddr] <= r_cmd.flag;
        end
        if (mem_re) begin
            r_rd_flag <= r_flag_mem[raddr];
        end
    end

endmodule

// File: rtl/core/dhks_outq.sv
// Result queue: holds up to two finished results until they are popped.
// Depends on dhks_pkg.
`timescale 1ns / 1ps

module dhks_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dhks_pkg::t_res i_res,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output dhks_pkg::t_res o_res
);
    import dhks_pkg::*;

    t_res       r_q [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_cnt, n_cnt;
    logic       push_ok;
    logic       pop_ok;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_res   = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ push_ok;
        n_rd_ptr = r_rd_ptr ^ pop_ok;
        n_cnt    = r_cnt + 2'(push_ok) - 2'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wr_ptr] <= i_res;
        end
    end

endmodule

// File: rtl/core/dhks_checker.sv
// Port-level checks for the double-hashed key set, bound to the top level.
// Depends on dhks_pkg and double_hash_key_set_top.
`timescale 1ns / 1ps

module dhks_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          full,
    input logic                          empty,
    input logic                          pop,
    input logic                          o_found,
    input logic [7:0]                    o_flag_out,
    input logic                          o_processed,
    input logic [dhks_pkg::SLOT_W-1:0]   o_slot,
    input logic                          o_newly_added,
    input logic                          o_table_full,
    input logic [dhks_pkg::COUNT_W-1:0]  o_entry_count
);
    import dhks_pkg::*;

    a_clear_blocks_input: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> full)
        else $error("input taken while the key memory is being cleared");

    a_processed_needs_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_processed) |-> (o_found && (o_flag_out == FLAG_PROCESSED)))
        else $error("processed reported without a matched processed flag");

    a_added_excludes_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_newly_added) |-> (!o_found && !o_table_full))
        else $error("new entry reported together with a match or a full table");

    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_slot) && $stable(o_entry_count)))
        else $error("waiting result changed before its transfer");

endmodule

bind double_hash_key_set_top dhks_checker u_dhks_checker (.*);
